@@ src/ppv_pkg.sv @@
// Shared constants, codes and types for the point pillar voxelizer.
`default_nettype none
package ppv_pkg;

  localparam int GRID_X     = 512;
  localparam int GRID_Y     = 512;
  localparam int GRID_Z     = 1;
  localparam int VOXEL_CAP  = 16384;
  localparam int POINT_CAP  = 64;

  localparam int CELLS  = GRID_X * GRID_Y * GRID_Z;
  localparam int KEY_W  = $clog2(CELLS);
  localparam int VIDX_W = $clog2(VOXEL_CAP);
  localparam int LG_X   = $clog2(GRID_X);
  localparam int LG_Y   = $clog2(GRID_Y);
  localparam int LG_Z   = $clog2(GRID_Z);

  // status codes
  localparam logic [2:0] ST_STORED  = 3'd0;
  localparam logic [2:0] ST_RANGE   = 3'd1;
  localparam logic [2:0] ST_LIMIT   = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_CLEARED = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_MIN_X  = 3'd0;
  localparam logic [2:0] CFG_MIN_Y  = 3'd1;
  localparam logic [2:0] CFG_MIN_Z  = 3'd2;
  localparam logic [2:0] CFG_INV_X  = 3'd3;
  localparam logic [2:0] CFG_INV_Y  = 3'd4;
  localparam logic [2:0] CFG_INV_Z  = 3'd5;
  localparam logic [2:0] CFG_VLIMIT = 3'd6;
  localparam logic [2:0] CFG_PLIMIT = 3'd7;

  // axis codes
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_MUL_LO,
    S_MUL_HI,
    S_CHECK,
    S_LOOKUP,
    S_FETCH,
    S_DECIDE
  } state_e;

endpackage
`default_nettype wire

@@ src/point_pillar_voxelizer_int8.sv @@
// Top level of the point pillar voxelizer: sequencer, shared multiplier, map memories.
`default_nettype none
// Channel | Signals                          | Item
// --------+----------------------------------+------------------------------------
// in      | in_valid_i / in_ready_o          | action, point_x/y/z, intensity
// out     | out_valid_o / out_ready_i        | status, indices, cells, features, total
// cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i | one register write, no handshake
//
// A clear item finishes in the cycle it is taken. A point item runs through
// two passes of one 21x13 multiplier plus a range check for each of the three axes,
// then map lookup, back-pointer/count fetch and the update.
// Out of range points leave early after the failing axis check.
// After reset the cell map is swept to zero, one entry a cycle over all CELLS
// entries; no item is taken meanwhile. A clear item only resets the voxel count:
// a map entry counts only if it points below that count and its voxel points back.
// in_ready_o is low while a result waits in the output register.
module point_pillar_voxelizer_int8 (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [23:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               action_i,
  input  wire logic signed [19:0] point_x_i,
  input  wire logic signed [19:0] point_y_i,
  input  wire logic signed [19:0] point_z_i,
  input  wire logic signed [15:0] intensity_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [2:0]              status_o,
  output logic [13:0]             voxel_index_o,
  output logic [5:0]              slot_index_o,
  output logic                    new_voxel_o,
  output logic [8:0]              cell_x_o,
  output logic [8:0]              cell_y_o,
  output logic [5:0]              cell_z_o,
  output logic signed [7:0]       feat_x_o,
  output logic signed [7:0]       feat_y_o,
  output logic signed [7:0]       feat_z_o,
  output logic signed [7:0]       feat_intensity_o,
  output logic [14:0]             voxel_total_o
);
  import ppv_pkg::*;

  // configuration
  logic signed [19:0] min_x_q, min_y_q, min_z_q;
  logic [23:0]        inv_x_q, inv_y_q, inv_z_q;
  logic [14:0]        vlimit_q;
  logic [6:0]         plimit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q  <= '0;
      min_y_q  <= '0;
      min_z_q  <= '0;
      inv_x_q  <= 24'd65536;
      inv_y_q  <= 24'd65536;
      inv_z_q  <= 24'd65536;
      vlimit_q <= 15'd16384;
      plimit_q <= 7'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_X:  min_x_q  <= cfg_wdata_i[19:0];
        CFG_MIN_Y:  min_y_q  <= cfg_wdata_i[19:0];
        CFG_MIN_Z:  min_z_q  <= cfg_wdata_i[19:0];
        CFG_INV_X:  inv_x_q  <= cfg_wdata_i;
        CFG_INV_Y:  inv_y_q  <= cfg_wdata_i;
        CFG_INV_Z:  inv_z_q  <= cfg_wdata_i;
        CFG_VLIMIT: vlimit_q <= cfg_wdata_i[14:0];
        CFG_PLIMIT: plimit_q <= cfg_wdata_i[6:0];
        default:    ;
      endcase
    end
  end

  // effective limits
  logic [14:0] vlim;
  logic [6:0]  plim;
  assign vlim = (vlimit_q < 15'(VOXEL_CAP)) ? vlimit_q : 15'(VOXEL_CAP);
  assign plim = (plimit_q < 7'(POINT_CAP)) ? plimit_q : 7'(POINT_CAP);

  // control and datapath registers
  state_e state_q, state_d;
  logic [1:0]          axis_q, axis_d;
  logic [KEY_W-1:0]    init_q;
  logic signed [19:0]  px_q, py_q, pz_q;
  logic signed [15:0]  int_q;
  logic signed [45:0]  acc_q, acc_d;
  logic [8:0]          cx_q, cy_q;
  logic [5:0]          cz_q;
  logic [7:0]          fx_q, fy_q, fz_q;
  logic [14:0]         used_q, used_d;
  logic                out_valid_q;

  logic in_acc;
  assign in_ready_o = (state_q == S_IDLE) && !out_valid_q;
  assign in_acc     = in_valid_i && in_ready_o;

  // shared multiplier: difference times one 12-bit half of the inverse size
  logic signed [20:0] diff;
  logic [23:0]        inv_sel;
  logic signed [12:0] mul_b;
  logic signed [33:0] mul_p;

  always_comb begin
    case (axis_q)
      AX_X:    begin diff = 21'(px_q) - 21'(min_x_q); inv_sel = inv_x_q; end
      AX_Y:    begin diff = 21'(py_q) - 21'(min_y_q); inv_sel = inv_y_q; end
      default: begin diff = 21'(pz_q) - 21'(min_z_q); inv_sel = inv_z_q; end
    endcase
    mul_b = (state_q == S_MUL_HI) ? $signed({1'b0, inv_sel[23:12]})
                                  : $signed({1'b0, inv_sel[11:0]});
    mul_p = diff * mul_b;
  end

  // axis check on the finished product
  logic        neg, outside;
  logic [20:0] cell_all;
  logic [45:0] fsum;
  logic [45:0] fq;
  logic [7:0]  feat;

  always_comb begin
    neg      = acc_q[45];
    cell_all = acc_q[44:24];
    case (axis_q)
      AX_X: begin
        outside = cell_all >= 21'(GRID_X);
        fsum    = 46'(acc_q) + (46'(GRID_X) << 16);
        fq      = fsum >> (17 + LG_X);
      end
      AX_Y: begin
        outside = cell_all >= 21'(GRID_Y);
        fsum    = 46'(acc_q) + (46'(GRID_Y) << 16);
        fq      = fsum >> (17 + LG_Y);
      end
      default: begin
        outside = cell_all >= 21'(GRID_Z);
        fsum    = 46'(acc_q) + (46'(GRID_Z) << 16);
        fq      = fsum >> (17 + LG_Z);
      end
    endcase
    feat = (fq > 46'd127) ? 8'd127 : fq[7:0];
  end

  // cell key
  logic [KEY_W-1:0] key;
  assign key = KEY_W'((int'(cz_q) * GRID_Y + int'(cy_q)) * GRID_X + int'(cx_q));

  // memories: cell map (voxel index + 1, 0 empty), voxel back-pointer, point count
  logic [14:0]        map_mem [CELLS];
  logic [KEY_W-1:0]   v2c_mem [VOXEL_CAP];
  logic [6:0]         cnt_mem [VOXEL_CAP];
  logic [14:0]        map_rd_q;
  logic [KEY_W-1:0]   v2c_rd_q;
  logic [6:0]         cnt_rd_q;

  logic               map_we, v2c_we, cnt_we;
  logic [KEY_W-1:0]   map_wa;
  logic [14:0]        map_wd;
  logic [VIDX_W-1:0]  vox_wa;
  logic [6:0]         cnt_wd;
  logic [VIDX_W-1:0]  eidx;

  assign eidx = VIDX_W'(map_rd_q - 15'd1);

  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    if (state_q == S_LOOKUP) map_rd_q <= map_mem[key];
  end

  always_ff @(posedge clk_i) begin
    if (v2c_we) v2c_mem[vox_wa] <= key;
    if (state_q == S_FETCH) v2c_rd_q <= v2c_mem[eidx];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[vox_wa] <= cnt_wd;
    if (state_q == S_FETCH) cnt_rd_q <= cnt_mem[eidx];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT:   if (init_q == KEY_W'(CELLS - 1)) state_d = S_IDLE;
      S_IDLE:   if (in_acc && !action_i) state_d = S_MUL_LO;
      S_MUL_LO: state_d = S_MUL_HI;
      S_MUL_HI: state_d = S_CHECK;
      S_CHECK: begin
        if (neg || outside)    state_d = S_IDLE;
        else if (axis_q == AX_Z) state_d = S_LOOKUP;
        else                   state_d = S_MUL_LO;
      end
      S_LOOKUP: state_d = S_FETCH;
      S_FETCH:  state_d = S_DECIDE;
      S_DECIDE: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // result assembly and memory updates
  logic        load;
  logic [2:0]  r_status;
  logic [13:0] r_vidx;
  logic [5:0]  r_slot;
  logic        r_new;
  logic [8:0]  r_cx, r_cy;
  logic [5:0]  r_cz;
  logic [7:0]  r_fx, r_fy, r_fz, r_fi;
  logic        hit, stored;
  logic signed [16:0] ihalf;

  always_comb begin
    ihalf = (int_q >= 0) ? ((17'(int_q) + 17'sd1) >>> 1) : (17'(int_q) >>> 1);
  end

  always_comb begin
    load     = 1'b0;
    r_status = ST_STORED;
    r_vidx   = '0;
    r_slot   = '0;
    r_new    = 1'b0;
    r_cx     = '0;
    r_cy     = '0;
    r_cz     = '0;
    r_fx     = '0;
    r_fy     = '0;
    r_fz     = '0;
    r_fi     = '0;
    used_d   = used_q;
    acc_d    = acc_q;
    axis_d   = axis_q;
    map_we   = 1'b0;
    map_wa   = key;
    map_wd   = used_q + 15'd1;
    v2c_we   = 1'b0;
    cnt_we   = 1'b0;
    vox_wa   = eidx;
    cnt_wd   = cnt_rd_q + 7'd1;
    stored   = 1'b0;
    hit      = (map_rd_q != 15'd0) && (map_rd_q <= used_q) && (v2c_rd_q == key);

    unique case (state_q)
      S_INIT: begin
        map_we = 1'b1;
        map_wa = init_q;
        map_wd = '0;
      end
      S_IDLE: begin
        axis_d = AX_X;
        if (in_acc && action_i) begin
          load     = 1'b1;
          r_status = ST_CLEARED;
          used_d   = '0;
        end
      end
      S_MUL_LO: acc_d = 46'(mul_p);
      S_MUL_HI: acc_d = acc_q + (46'(mul_p) <<< 12);
      S_CHECK: begin
        if (neg || outside) begin
          load     = 1'b1;
          r_status = ST_RANGE;
        end else begin
          axis_d = axis_q + 2'd1;
        end
      end
      S_DECIDE: begin
        r_cx = cx_q;
        r_cy = cy_q;
        r_cz = cz_q;
        load = 1'b1;
        if (!hit) begin
          if (used_q >= vlim) begin
            r_status = ST_LIMIT;
          end else begin
            r_new  = 1'b1;
            r_vidx = used_q[13:0];
            used_d = used_q + 15'd1;
            map_we = 1'b1;
            v2c_we = 1'b1;
            cnt_we = 1'b1;
            vox_wa = VIDX_W'(used_q);
            // a new voxel always gets its count written, zero when nothing fits
            if (plim != 7'd0) begin
              stored = 1'b1;
              cnt_wd = 7'd1;
            end else begin
              cnt_wd   = 7'd0;
              r_status = ST_FULL;
            end
          end
        end else begin
          r_vidx = 14'(eidx);
          if (cnt_rd_q < plim) begin
            stored = 1'b1;
            r_slot = cnt_rd_q[5:0];
            cnt_we = 1'b1;
          end else begin
            r_status = ST_FULL;
          end
        end
        if (stored) begin
          r_status = ST_STORED;
          r_fx     = fx_q;
          r_fy     = fy_q;
          r_fz     = fz_q;
          r_fi     = (ihalf > 17'sd127) ? 8'd127 :
                     (ihalf < -17'sd128) ? 8'h80 : ihalf[7:0];
        end
      end
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      init_q      <= '0;
      axis_q      <= AX_X;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      used_q  <= used_d;
      if (state_q == S_INIT) init_q <= init_q + 1'b1;
      if (load)              out_valid_q <= 1'b1;
      else if (out_ready_i)  out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (in_acc) begin
      px_q  <= point_x_i;
      py_q  <= point_y_i;
      pz_q  <= point_z_i;
      int_q <= intensity_i;
    end
    if (state_q == S_CHECK) begin
      case (axis_q)
        AX_X:    begin cx_q <= cell_all[8:0]; fx_q <= feat; end
        AX_Y:    begin cy_q <= cell_all[8:0]; fy_q <= feat; end
        default: begin cz_q <= cell_all[5:0]; fz_q <= feat; end
      endcase
    end
    if (load) begin
      status_o         <= r_status;
      voxel_index_o    <= r_vidx;
      slot_index_o     <= r_slot;
      new_voxel_o      <= r_new;
      cell_x_o         <= r_cx;
      cell_y_o         <= r_cy;
      cell_z_o         <= r_cz;
      feat_x_o         <= r_fx;
      feat_y_o         <= r_fy;
      feat_z_o         <= r_fz;
      feat_intensity_o <= r_fi;
      voxel_total_o    <= used_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

@@ tb/ppv_checker.sv @@
// Checker for the point pillar voxelizer: watches the cfg, in and out channels, predicts results and compares.
module ppv_checker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [23:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire logic               action_i,
  input  wire logic signed [19:0] point_x_i,
  input  wire logic signed [19:0] point_y_i,
  input  wire logic signed [19:0] point_z_i,
  input  wire logic signed [15:0] intensity_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire logic [2:0]         status_i,
  input  wire logic [13:0]        voxel_index_i,
  input  wire logic [5:0]         slot_index_i,
  input  wire logic               new_voxel_i,
  input  wire logic [8:0]         cell_x_i,
  input  wire logic [8:0]         cell_y_i,
  input  wire logic [5:0]         cell_z_i,
  input  wire logic signed [7:0]  feat_x_i,
  input  wire logic signed [7:0]  feat_y_i,
  input  wire logic signed [7:0]  feat_z_i,
  input  wire logic signed [7:0]  feat_intensity_i,
  input  wire logic [14:0]        voxel_total_i,
  output int                      fail_count_o,
  output int                      pending_o
);
  import ppv_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [13:0] vidx;
    logic [5:0]  slot;
    logic        isnew;
    logic [8:0]  cx;
    logic [8:0]  cy;
    logic [5:0]  cz;
    logic [7:0]  fx;
    logic [7:0]  fy;
    logic [7:0]  fz;
    logic [7:0]  fi;
    logic [14:0] total;
  } vox_result_t;

  vox_result_t expected_q[$];

  // map entry 0 = empty, else voxel index + 1
  int unsigned cell_map[int unsigned];
  int unsigned fill_count[int unsigned];
  int unsigned voxels_made;

  longint min_x, min_y, min_z;
  longint inv_x, inv_y, inv_z;
  longint vlimit, plimit;

  assign pending_o = expected_q.size();

  function automatic logic axis_cell(input longint p, input longint lo, input longint inv,
                                     input longint grid, output longint cell_pos,
                                     output logic [7:0] feat);
    longint prod, f;
    prod = (p - lo) * inv;
    cell_pos = 0;
    feat = '0;
    if (prod < 0) return 1'b0;
    cell_pos = prod >>> 24;
    if (cell_pos >= grid) return 1'b0;
    f = (prod + (grid << 16)) / (grid << 17);
    if (f > 127) f = 127;
    feat = f[7:0];
    return 1'b1;
  endfunction

  function automatic vox_result_t place_point(input logic act, input longint px,
                                              input longint py, input longint pz,
                                              input longint inten);
    vox_result_t r;
    longint cx, cy, cz, fi, vl, pl;
    logic [7:0] fx, fy, fz;
    int unsigned key, entry, vidx;
    logic ok;
    r = '0;
    if (act) begin
      cell_map.delete();
      fill_count.delete();
      voxels_made = 0;
      r.status = ST_CLEARED;
    end else begin
      ok = axis_cell(px, min_x, inv_x, GRID_X, cx, fx);
      if (ok) ok = axis_cell(py, min_y, inv_y, GRID_Y, cy, fy);
      if (ok) ok = axis_cell(pz, min_z, inv_z, GRID_Z, cz, fz);
      if (!ok) begin
        r.status = ST_RANGE;
      end else begin
        r.cx = cx[8:0];
        r.cy = cy[8:0];
        r.cz = cz[5:0];
        key = int'((cz * GRID_Y + cy) * GRID_X + cx);
        entry = cell_map.exists(key) ? cell_map[key] : 0;
        vl = vlimit < VOXEL_CAP ? vlimit : VOXEL_CAP;
        pl = plimit < POINT_CAP ? plimit : POINT_CAP;
        if (entry == 0 && voxels_made >= vl) begin
          r.status = ST_LIMIT;
        end else begin
          if (entry == 0) begin
            vidx = voxels_made;
            voxels_made++;
            cell_map[key] = vidx + 1;
            fill_count[vidx] = 0;
            r.isnew = 1'b1;
          end else begin
            vidx = entry - 1;
          end
          r.vidx = vidx[13:0];
          if (fill_count[vidx] < pl) begin
            r.slot = fill_count[vidx][5:0];
            fill_count[vidx]++;
            r.status = ST_STORED;
            fi = inten >= 0 ? (inten + 1) / 2 : -((-inten + 1) / 2);
            if (fi > 127) fi = 127;
            if (fi < -128) fi = -128;
            r.fx = fx;
            r.fy = fy;
            r.fz = fz;
            r.fi = fi[7:0];
          end else begin
            r.status = ST_FULL;
          end
        end
      end
    end
    r.total = voxels_made[14:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  vox_result_t got, want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_map.delete();
      fill_count.delete();
      voxels_made = 0;
      min_x = 0; min_y = 0; min_z = 0;
      inv_x = 65536; inv_y = 65536; inv_z = 65536;
      vlimit = 16384;
      plimit = 64;
      expected_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIN_X:  min_x = longint'($signed(cfg_wdata_i[19:0]));
          CFG_MIN_Y:  min_y = longint'($signed(cfg_wdata_i[19:0]));
          CFG_MIN_Z:  min_z = longint'($signed(cfg_wdata_i[19:0]));
          CFG_INV_X:  inv_x = longint'(cfg_wdata_i);
          CFG_INV_Y:  inv_y = longint'(cfg_wdata_i);
          CFG_INV_Z:  inv_z = longint'(cfg_wdata_i);
          CFG_VLIMIT: vlimit = longint'(cfg_wdata_i[14:0]);
          CFG_PLIMIT: plimit = longint'(cfg_wdata_i[6:0]);
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        expected_q.push_back(place_point(action_i, point_x_i, point_y_i, point_z_i,
                                         intensity_i));
      if (out_valid_i && out_ready_i) begin
        got = '{status_i, voxel_index_i, slot_index_i, new_voxel_i, cell_x_i, cell_y_i,
                cell_z_i, feat_x_i, feat_y_i, feat_z_i, feat_intensity_i, voxel_total_i};
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result, status", got.status, -1);
        end else begin
          want = expected_q.pop_front();
          if (got.status !== want.status) report_mismatch("status", got.status, want.status);
          if (got.vidx !== want.vidx) report_mismatch("voxel_index", got.vidx, want.vidx);
          if (got.slot !== want.slot) report_mismatch("slot_index", got.slot, want.slot);
          if (got.isnew !== want.isnew) report_mismatch("new_voxel", got.isnew, want.isnew);
          if (got.cx !== want.cx) report_mismatch("cell_x", got.cx, want.cx);
          if (got.cy !== want.cy) report_mismatch("cell_y", got.cy, want.cy);
          if (got.cz !== want.cz) report_mismatch("cell_z", got.cz, want.cz);
          if (got.fx !== want.fx)
            report_mismatch("feat_x", $signed(got.fx), $signed(want.fx));
          if (got.fy !== want.fy)
            report_mismatch("feat_y", $signed(got.fy), $signed(want.fy));
          if (got.fz !== want.fz)
            report_mismatch("feat_z", $signed(got.fz), $signed(want.fz));
          if (got.fi !== want.fi)
            report_mismatch("feat_intensity", $signed(got.fi), $signed(want.fi));
          if (got.total !== want.total)
            report_mismatch("voxel_total", got.total, want.total);
        end
      end
    end
  end

endmodule

@@ tb/tb_point_pillar_voxelizer_int8.sv @@
// Testbench top for the point pillar voxelizer: stimulus, flow control and verdict.
module tb_point_pillar_voxelizer_int8;
  import ppv_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [23:0]        cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               action_i = 1'b0;
  logic signed [19:0] point_x_i = '0;
  logic signed [19:0] point_y_i = '0;
  logic signed [19:0] point_z_i = '0;
  logic signed [15:0] intensity_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [2:0]         status_o;
  logic [13:0]        voxel_index_o;
  logic [5:0]         slot_index_o;
  logic               new_voxel_o;
  logic [8:0]         cell_x_o;
  logic [8:0]         cell_y_o;
  logic [5:0]         cell_z_o;
  logic signed [7:0]  feat_x_o;
  logic signed [7:0]  feat_y_o;
  logic signed [7:0]  feat_z_o;
  logic signed [7:0]  feat_intensity_o;
  logic [14:0]        voxel_total_o;

  int fail_count;
  int pending;

  // percent of cycles each side idles; hold_off forces a long receiver stall
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;

  always #6 clk_i = ~clk_i;

  point_pillar_voxelizer_int8 uut (.*);

  ppv_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .action_i, .point_x_i, .point_y_i,
    .point_z_i, .intensity_i, .out_valid_i(out_valid_o), .out_ready_i,
    .status_i(status_o), .voxel_index_i(voxel_index_o), .slot_index_i(slot_index_o),
    .new_voxel_i(new_voxel_o), .cell_x_i(cell_x_o), .cell_y_i(cell_y_o),
    .cell_z_i(cell_z_o), .feat_x_i(feat_x_o), .feat_y_i(feat_y_o), .feat_z_i(feat_z_o),
    .feat_intensity_i(feat_intensity_o), .voxel_total_i(voxel_total_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Receiver: random stalls, plus a long hold-off while hold_off is set.
  always @(negedge clk_i) begin
    if (hold_off) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Pressure: receiver blocked for a long stretch, counted here.
  task automatic long_hold_off();
    int n;
    hold_off = 1'b1;
    for (n = 0; n < 300; n++) @(negedge clk_i);
    hold_off = 1'b0;
  endtask

  // Offer one item and hold it until in_ready_o is sampled high on the rising clock. Valid
  // drops only while idling or in drain(), so back-to-back items keep it high.
  task automatic send_point(input logic act, input logic signed [19:0] px,
                            input logic signed [19:0] py, input logic signed [19:0] pz,
                            input logic signed [15:0] inten);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    point_x_i <= px;
    point_y_i <= py;
    point_z_i <= pz;
    intensity_i <= inten;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // One register write; configure() drops the write enable after the last.
  task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
  endtask

  // Wait until every expected result has come back, then let the pipeline drain.
  task automatic drain();
    int n;
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    for (n = 0; n < 20; n++) @(negedge clk_i);
  endtask

  // Random point near the grid: mostly inside a small window so cells repeat
  // and voxels fill, sometimes anywhere in the 20-bit range.
  task automatic random_point(input int window);
    logic signed [19:0] px, py, pz;
    logic act;
    act = ($urandom_range(99) < 2);
    if ($urandom_range(99) < 85) begin
      px = 20'($urandom_range(window));
      py = 20'($urandom_range(window));
      pz = 20'($urandom_range(255));
    end else begin
      px = 20'($urandom);
      py = 20'($urandom);
      pz = 20'($urandom);
    end
    send_point(act, px, py, pz, 16'($urandom));
  endtask

  // One configuration setting: grid bounds, scales and limits.
  task automatic configure(input logic [19:0] mx, input logic [19:0] my,
                           input logic [19:0] mz, input logic [23:0] ix,
                           input logic [23:0] iy, input logic [23:0] iz,
                           input logic [14:0] vl, input logic [6:0] pl);
    write_reg(CFG_MIN_X, {{4{mx[19]}}, mx});
    write_reg(CFG_MIN_Y, {{4{my[19]}}, my});
    write_reg(CFG_MIN_Z, {{4{mz[19]}}, mz});
    write_reg(CFG_INV_X, ix);
    write_reg(CFG_INV_Y, iy);
    write_reg(CFG_INV_Z, iz);
    write_reg(CFG_VLIMIT, {9'd0, vl});
    write_reg(CFG_PLIMIT, {17'd0, pl});
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int i, phase;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: field extremes, clear, out of range on each axis, saturation.
    send_point(1'b0, 20'sd0, 20'sd0, 20'sd0, 16'sd0);
    send_point(1'b0, 20'sd0, 20'sd0, 20'sd0, 16'sd32767);
    send_point(1'b0, 20'sd1, 20'sd2, 20'sd3, -16'sd32768);
    send_point(1'b0, 20'sd255, 20'sd255, 20'sd255, 16'sd1);
    send_point(1'b0, 20'sd0, 20'sd0, 20'sd0, -16'sd1);
    send_point(1'b0, 20'sd0, 20'sd0, 20'sd0, -16'sd3);
    send_point(1'b0, -20'sd1, 20'sd0, 20'sd0, 16'sd5);          // x below grid
    send_point(1'b0, 20'sd0, -20'sd524288, 20'sd0, 16'sd5);     // y below grid
    send_point(1'b0, 20'sd0, 20'sd0, 20'sd256, 16'sd5);         // z above grid
    send_point(1'b0, 20'sd131071, 20'sd131071, 20'sd0, 16'sd255); // top corner cell
    send_point(1'b0, 20'sd131072, 20'sd0, 20'sd0, 16'sd0);      // x one past grid
    send_point(1'b0, 20'sd524287, 20'sd524287, 20'sd524287, 16'sd0);
    send_point(1'b1, 20'sd524287, -20'sd1, 20'sd7, 16'sd9);     // clear
    send_point(1'b0, 20'sd0, 20'sd0, 20'sd0, 16'sd0);
    drain();

    // Zero limits: every new cell rejected, then every voxel full.
    configure(20'd0, 20'd0, 20'd0, 24'd65536, 24'd65536, 24'd65536, 15'd0, 7'd64);
    send_point(1'b0, 20'sd300, 20'sd300, 20'sd0, 16'sd7);       // new cell, limit hit
    send_point(1'b0, 20'sd0, 20'sd0, 20'sd0, 16'sd7);           // existing cell
    drain();
    configure(20'd0, 20'd0, 20'd0, 24'd65536, 24'd65536, 24'd65536, 15'd16384, 7'd0);
    send_point(1'b0, 20'sd600, 20'sd600, 20'sd0, 16'sd7);       // new voxel, full
    send_point(1'b1, 20'sd0, 20'sd0, 20'sd0, 16'sd0);
    drain();

    // Pressure: keep offering while the receiver is blocked.
    fork
      long_hold_off();
      for (i = 0; i < 6; i++) random_point(2000);
    join
    drain();

    // Random phases with different settings and flow control.
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      case (phase)
        0: configure(20'd0, 20'd0, 20'd0, 24'd65536, 24'd65536, 24'd65536,
                     15'd16384, 7'd64);
        1: configure(-20'sd1000, -20'sd1000, -20'sd100, 24'd262144, 24'd262144,
                     24'd16384, 15'd20, 7'd3);
        2: configure(20'h80000, 20'h80000, 20'h80000, 24'hFFFFFF, 24'hFFFFFF,
                     24'hFFFFFF, 15'h7FFF, 7'h7F);
        3: configure(20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 24'd0, 24'd0, 24'd0, 15'd1, 7'd1);
        4: configure(20'd0, 20'd0, -20'sd50, 24'd4096, 24'd4096, 24'd1024, 15'd5, 7'd64);
        5: configure(-20'sd200, 20'd10, 20'd0, 24'd1000000, 24'd700000, 24'd300,
                     15'd300, 7'd2);
        6: configure(20'($urandom), 20'($urandom), 20'($urandom), 24'($urandom),
                     24'($urandom), 24'($urandom), 15'($urandom), 7'($urandom));
        default: configure(20'd0, 20'd0, 20'd0, 24'd131072, 24'd65536, 24'd65536,
                           15'd8, 7'd4);
      endcase
      for (i = 0; i < 118; i++) random_point(phase == 2 ? 524287 : 4000);
      drain();
    end

    if (fail_count == 0) begin
      $display("PASS point_pillar_voxelizer_int8");
    end else begin
      $display("FAIL point_pillar_voxelizer_int8");
    end
    $finish;
  end

  // Covers the map sweep after reset plus a slow run.
  initial begin
    #(12 * 900000);
    $display("FAIL point_pillar_voxelizer_int8");
    $finish;
  end

endmodule
